// File: rtl/core/dre_pkg.sv
// ----------------------------------------------------------------------------
// dre_pkg
// Shared widths, constants and types of the differing-run extractor.
// ----------------------------------------------------------------------------
package dre_pkg;

    localparam int OFS_W        = 24;
    localparam int LEN_W        = 17;
    localparam int BYTE_W       = 8;
    localparam int BUFFER_BYTES = 16777216;

    localparam logic [OFS_W-1:0] BUF_LAST   = OFS_W'(BUFFER_BYTES - 1);
    localparam logic [LEN_W-1:0] WIN_RESET  = LEN_W'(4096);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

    // words produced by one accepted byte pair
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: rtl/core/diff_run_extractor_top.sv
// ----------------------------------------------------------------------------
// diff_run_extractor_top
// Streams byte pairs of a local and a remote buffer and emits write runs.
//
// Input channel: one word per byte pair (local_byte, remote_byte, final_byte)
// in offset order, taken when in_valid is high and in_stall is low.
// Output channel: run words (run_offset, run_length, last_of_item), taken
// when out_valid is high and out_stall is low. A byte pair gives zero, one
// or two words; last_of_item marks the final word of a byte pair.
// Throughput: one byte pair per cycle while in_stall is low; one word out
// per cycle while out_stall is low. Run state and the queue update in the
// accepting cycle; words wait in a four-entry queue. in_stall rises while
// fewer than two entries are free, so a stalled receiver backs up the input
// once three or more words are queued. cfg_write_en/cfg_write_data write the
// window length; write it only while idle, which the block does not check.
// Reset: offset 0, no open run, empty queue, window length 4096.
// ----------------------------------------------------------------------------
module diff_run_extractor_top
    import dre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [LEN_W-1:0]  cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] local_byte,
    input  logic [BYTE_W-1:0] remote_byte,
    input  logic              final_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OFS_W-1:0]  run_offset,
    output logic [LEN_W-1:0]  run_length,
    output logic              last_of_item
);

    logic [LEN_W-1:0] win_len_reg;
    logic             accept;
    logic             room;
    push_t            push;
    result_t          head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WIN_RESET;
        end
        else if (cfg_write_en)
        begin
            win_len_reg <= cfg_write_data;
        end
    end

    assign in_stall = !room;
    assign accept   = in_valid && room;

    dre_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .local_byte  (local_byte),
        .remote_byte (remote_byte),
        .final_byte  (final_byte),
        .window      (win_len_reg),
        .push        (push)
    );

    dre_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (!out_stall),
        .room      (room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign run_offset   = head.offset;
    assign run_length   = head.length;
    assign last_of_item = head.last;

endmodule

// File: rtl/core/dre_update.sv
// ----------------------------------------------------------------------------
// dre_update
// Run tracking state and per-byte update; emits up to two run words per byte.
// ----------------------------------------------------------------------------
module dre_update
    import dre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] local_byte,
    input  logic [BYTE_W-1:0] remote_byte,
    input  logic              final_byte,
    input  logic [LEN_W-1:0]  window,
    output push_t             push
);

    logic [OFS_W-1:0] byte_index_reg, byte_index_next;
    logic             run_open_reg, run_open_next;
    logic [OFS_W-1:0] run_begin_reg, run_begin_next;
    logic [OFS_W-1:0] last_mismatch_reg, last_mismatch_next;

    logic [LEN_W-1:0] win;
    logic [OFS_W-1:0] run_age;
    logic             expire;
    logic             differ;
    logic             fin;
    logic             open_mid;
    logic             open_all;
    logic [OFS_W-1:0] span_old;
    logic [OFS_W-1:0] span_new;
    result_t          res_old;
    result_t          res_new;
    logic             emit_new;

    always_comb
    begin
        win      = (window == '0) ? LEN_W'(1) : window;
        run_age  = byte_index_reg - run_begin_reg;
        expire   = run_open_reg && (run_age >= {{(OFS_W-LEN_W){1'b0}}, win});
        differ   = (local_byte != remote_byte);
        fin      = final_byte || (byte_index_reg == BUF_LAST);
        open_mid = run_open_reg && !expire;
        open_all = open_mid || differ;

        run_begin_next     = (differ && !open_mid) ? byte_index_reg : run_begin_reg;
        last_mismatch_next = differ ? byte_index_reg : last_mismatch_reg;
        emit_new           = fin && open_all;
        run_open_next      = open_all && !fin;
        byte_index_next    = fin ? '0 : byte_index_reg + OFS_W'(1);

        span_old       = last_mismatch_reg - run_begin_reg;
        span_new       = last_mismatch_next - run_begin_next;
        res_old.offset = run_begin_reg;
        res_old.length = span_old[LEN_W-1:0] + LEN_W'(1);
        res_old.last   = !emit_new;
        res_new.offset = run_begin_next;
        res_new.length = span_new[LEN_W-1:0] + LEN_W'(1);
        res_new.last   = 1'b1;

        push.count  = accept ? ({1'b0, expire} + {1'b0, emit_new}) : 2'd0;
        push.first  = expire ? res_old : res_new;
        push.second = res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            run_open_reg      <= 1'b0;
            run_begin_reg     <= '0;
            last_mismatch_reg <= '0;
        end
        else if (accept)
        begin
            byte_index_reg    <= byte_index_next;
            run_open_reg      <= run_open_next;
            run_begin_reg     <= run_begin_next;
            last_mismatch_reg <= last_mismatch_next;
        end
    end

endmodule

// File: rtl/core/dre_fifo.sv
// ----------------------------------------------------------------------------
// dre_fifo
// Result queue; takes up to two words per cycle, delivers one per cycle while pop is high.
// ----------------------------------------------------------------------------
module dre_fifo
    import dre_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    not_empty,
    output result_t head
);

    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(do_pop);
        room        = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
        not_empty   = (count_reg != '0);
        head        = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_ONE] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks diff_run_extractor_top: byte pairs of two buffers stream in, and the
// write runs that come out are compared word by word against a local model of
// the run tracker. A directed table covers the window extremes, window expiry
// together with the end of a pass, and runs of full window length. Random
// buffer passes follow under several window settings, with bursty input and a
// receiver that stalls, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import dre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_PAIRS    = 240;
    localparam int NUM_PHASES     = 5;

    typedef enum logic [1:0] {ROW_WIN, ROW_BYTES} row_kind_e;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

    typedef struct packed {
        row_kind_e         kind;
        int                arg;     // window value, or repeat count
        logic [BYTE_W-1:0] lb;
        logic [BYTE_W-1:0] rb;
        logic              fin;
        int                nexp;    // -1: use the model
        logic [OFS_W-1:0]  o0;
        logic [LEN_W-1:0]  l0;
        logic [OFS_W-1:0]  o1;
        logic [LEN_W-1:0]  l1;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [28] = '{
        '{ROW_BYTES, 1,     8'h00, 8'h00, 1'b1, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'hFF, 8'h00, 1'b1, 1,  24'd0,    17'd1,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h00, 8'hFF, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 20,    8'hAA, 8'hAA, 1'b0, -1, 24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h55, 8'h54, 1'b1, 1,  24'd0,    17'd22,    24'd0, 17'd0},
        // zero window acts as one byte
        '{ROW_WIN,   0,     8'h00, 8'h00, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h12, 8'h34, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h56, 8'h78, 1'b0, 1,  24'd0,    17'd1,     24'd0, 17'd0},
        // expiry and end of pass on a differing byte: two words
        '{ROW_BYTES, 1,     8'h9A, 8'hBC, 1'b1, 2,  24'd1,    17'd1,     24'd2, 17'd1},
        '{ROW_WIN,   3,     8'h00, 8'h00, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h01, 8'h00, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 2,     8'h00, 8'h00, 1'b0, -1, 24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h00, 8'h00, 1'b1, 1,  24'd0,    17'd1,     24'd0, 17'd0},
        // run of full window length
        '{ROW_WIN,   4,     8'h00, 8'h00, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h10, 8'h20, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 2,     8'h77, 8'h77, 1'b0, -1, 24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h30, 8'h40, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h50, 8'h60, 1'b0, 1,  24'd0,    17'd4,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h00, 8'h00, 1'b1, 1,  24'd4,    17'd1,     24'd0, 17'd0},
        '{ROW_WIN,   65536, 8'h00, 8'h00, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'hFF, 8'hFE, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 30,    8'h33, 8'h33, 1'b0, -1, 24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h00, 8'h01, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h00, 8'h00, 1'b1, 1,  24'd0,    17'd32,    24'd0, 17'd0},
        // window above 65536 is taken as written
        '{ROW_WIN,   131071, 8'h00, 8'h00, 1'b0, 0, 24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h01, 8'h00, 1'b0, 0,  24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 40,    8'hC3, 8'hC3, 1'b0, -1, 24'd0,    17'd0,     24'd0, 17'd0},
        '{ROW_BYTES, 1,     8'h02, 8'h00, 1'b1, 1,  24'd0,    17'd42,    24'd0, 17'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write_en = 1'b0;
    logic [LEN_W-1:0]  cfg_write_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] local_byte = '0;
    logic [BYTE_W-1:0] remote_byte = '0;
    logic              final_byte = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OFS_W-1:0]  run_offset;
    logic [LEN_W-1:0]  run_length;
    logic              last_of_item;

    // run tracker model
    logic [LEN_W-1:0]  window_len = WIN_RESET;
    logic [OFS_W-1:0]  scan_pos = '0;
    logic              run_active = 1'b0;
    logic [OFS_W-1:0]  run_start = '0;
    logic [OFS_W-1:0]  last_diff = '0;

    result_t           pending_runs [$];
    result_t           want;
    int                mismatches = 0;
    int                idle_cycles = 0;
    int                burst_left = 0;

    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;
    int                hold_left = 0;
    rx_mode_e          rx_mode = RX_FREE;
    int                rx_mode_left = 0;

    diff_run_extractor_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .local_byte     (local_byte),
        .remote_byte    (remote_byte),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .run_offset     (run_offset),
        .run_length     (run_length),
        .last_of_item   (last_of_item)
    );

    always #4 clk = ~clk;

    function automatic result_t make_run(input logic [OFS_W-1:0] ofs,
                                         input logic [OFS_W-1:0] lastd);
        result_t          r;
        logic [OFS_W-1:0] span;
        span     = lastd - ofs;
        span     = span + 1'b1;
        r.offset = ofs;
        r.length = span[LEN_W-1:0];
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic int predict_runs(input logic [BYTE_W-1:0] lb,
                                        input logic [BYTE_W-1:0] rb,
                                        input logic fin_in,
                                        output result_t w0, output result_t w1);
        logic [OFS_W-1:0] pos;
        logic [OFS_W-1:0] win;
        logic             fin;
        int               n;
        result_t          words [2];
        pos      = scan_pos;
        win      = (window_len == '0) ? OFS_W'(1) : OFS_W'(window_len);
        fin      = fin_in || (pos == BUF_LAST);
        n        = 0;
        words[0] = '0;
        words[1] = '0;
        if (run_active && OFS_W'(pos - run_start) >= win)
        begin
            words[n]   = make_run(run_start, last_diff);
            n++;
            run_active = 1'b0;
        end
        if (lb != rb)
        begin
            if (!run_active)
            begin
                run_active = 1'b1;
                run_start  = pos;
            end
            last_diff = pos;
        end
        if (fin)
        begin
            if (run_active)
            begin
                words[n]   = make_run(run_start, last_diff);
                n++;
                run_active = 1'b0;
            end
            scan_pos = '0;
        end
        else
        begin
            scan_pos = pos + 1'b1;
        end
        if (n > 0)
            words[n-1].last = 1'b1;
        w0 = words[0];
        w1 = words[1];
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // called at a clock step; returns at the step the word was taken
    task automatic send_pair(input logic [BYTE_W-1:0] lb, input logic [BYTE_W-1:0] rb,
                             input logic fin, input int nexp,
                             input result_t t0, input result_t t1);
        int      gap;
        int      n;
        result_t p0;
        result_t p1;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        local_byte  <= lb;
        remote_byte <= rb;
        final_byte  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = predict_runs(lb, rb, fin, p0, p1);
        if (nexp >= 0)
        begin
            n  = nexp;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_runs.push_back(p0);
        if (n > 1)
            pending_runs.push_back(p1);
    endtask

    task automatic set_window(input logic [LEN_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        window_len = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_runs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word offset %0d length %0d",
                                          run_offset, run_length));
            end
            else
            begin
                want = pending_runs.pop_front();
                if (run_offset !== want.offset)
                    report_mismatch($sformatf("run_offset %0d, want %0d",
                                              run_offset, want.offset));
                if (run_length !== want.length)
                    report_mismatch($sformatf("run_length %0d, want %0d (offset %0d)",
                                              run_length, want.length, want.offset));
                if (last_of_item !== want.last)
                    report_mismatch($sformatf("last_of_item %0b, want %0b (offset %0d)",
                                              last_of_item, want.last, want.offset));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t         row;
        result_t           t0;
        result_t           t1;
        logic [LEN_W-1:0]  phase_win [NUM_PHASES];
        logic [BYTE_W-1:0] lb;
        logic [BYTE_W-1:0] rb;
        int                sent;
        int                pass_len;
        int                density;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PLAN[i])
        begin
            row = DIRECTED_PLAN[i];
            if (row.kind == ROW_WIN)
            begin
                set_window(LEN_W'(row.arg));
            end
            else
            begin
                t0 = '{offset: row.o0, length: row.l0, last: (row.nexp == 1)};
                t1 = '{offset: row.o1, length: row.l1, last: 1'b1};
                repeat (row.arg)
                    send_pair(row.lb, row.rb, row.fin, row.nexp, t0, t1);
            end
        end

        phase_win[0] = LEN_W'($urandom_range(1, 4));
        phase_win[1] = LEN_W'($urandom_range(5, 48));
        phase_win[2] = '0;
        phase_win[3] = LEN_W'($urandom_range(49, 400));
        phase_win[4] = LEN_W'($urandom_range(401, 131071));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_window(phase_win[ph]);
            if (ph == 2)
                hold_req = 1'b1;
            sent = 0;
            // whole buffer passes only, so no run is open at a window change
            while (sent < PHASE_PAIRS)
            begin
                pass_len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 300)
                                                       : $urandom_range(1, 64);
                density  = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(0, 60);
                for (int k = 0; k < pass_len; k++)
                begin
                    lb = BYTE_W'($urandom_range(0, 255));
                    rb = ($urandom_range(0, 99) < density)
                         ? lb ^ BYTE_W'($urandom_range(1, 255)) : lb;
                    send_pair(lb, rb, (k == pass_len - 1), -1, '0, '0);
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/dre_pkg.sv
rtl/core/dre_update.sv
rtl/core/dre_fifo.sv
rtl/core/diff_run_extractor_top.sv
dv/testbench.sv
